// ===== hdl/mnso_pkg.sv =====
// Shared types, constants and table functions of the MIDI note sine oscillator.
package mnso_pkg;

  localparam int PHASE_BITS_DEF     = 32;
  localparam int SINE_ADDR_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF    = 16;

  localparam int OP_W     = 2;
  localparam int NOTE_W   = 7;
  localparam int VEL_W    = 7;
  localparam int A4_W     = 31;
  localparam int RATIO_W  = 17;
  localparam int SEMI_W   = 4;
  localparam int OCT_W    = 4;
  localparam int KEY_W    = 8;
  localparam int INC_SHIFT = 22;

  localparam logic [A4_W-1:0]   A4_RESET   = 31'd39370534;
  localparam logic [NOTE_W-1:0] NOTE_RESET = 7'd69;
  localparam logic [KEY_W-1:0]  KEY_OFFSET = 8'd3;
  localparam logic [KEY_W-1:0]  SEMIS_PER_OCT = 8'd12;
  localparam logic [15:0]       OCT_RECIP = 16'd171;
  localparam int                OCT_RECIP_SHIFT = 11;
  localparam int                VEL_FULL = 127;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK     = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;

  typedef enum logic [1:0] {
    CMD_NOTE_ON,
    CMD_NOTE_OFF,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [SEMI_W-1:0] semi;
    logic [OCT_W-1:0]  oct;
    logic [VEL_W-1:0]  velocity;
  } mnso_cmd_t;

  typedef struct packed {
    logic [SEMI_W-1:0] semi;
    logic [OCT_W-1:0]  oct;
  } note_split_t;

  function automatic note_split_t note_split(input logic [NOTE_W-1:0] note);
    logic [KEY_W-1:0] key;
    logic [15:0]      prod;
    note_split_t      res;
    key      = {1'b0, note} + KEY_OFFSET;
    prod     = 16'(key) * OCT_RECIP;
    res.oct  = OCT_W'(prod >> OCT_RECIP_SHIFT);
    res.semi = SEMI_W'(key - 8'(res.oct) * SEMIS_PER_OCT);
    return res;
  endfunction

  function automatic logic [RATIO_W-1:0] ratio_lut(input logic [SEMI_W-1:0] semi);
    logic [RATIO_W-1:0] r;
    unique case (semi)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd69433;
      4'd2:    r = 17'd73562;
      4'd3:    r = 17'd77936;
      4'd4:    r = 17'd82570;
      4'd5:    r = 17'd87480;
      4'd6:    r = 17'd92682;
      4'd7:    r = 17'd98193;
      4'd8:    r = 17'd104032;
      4'd9:    r = 17'd110218;
      4'd10:   r = 17'd116772;
      4'd11:   r = 17'd123715;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Quarter-wave entry: an eleventh-order Taylor sine in Q30 with truncating steps,
  // scaled to full amplitude and rounded.
  function automatic int unsigned sine_entry(input int unsigned idx,
                                             input int unsigned addr_bits,
                                             input int unsigned sample_bits);
    longint unsigned one;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned amp;
    longint unsigned m;
    one = 64'd1 << 30;
    x   = (64'd1686629713 * longint'(idx)) >> addr_bits;
    x2  = (x * x) >> 30;
    t   = one;
    t   = one - ((x2 * t) >> 30) / 64'd110;
    t   = one - ((x2 * t) >> 30) / 64'd72;
    t   = one - ((x2 * t) >> 30) / 64'd42;
    t   = one - ((x2 * t) >> 30) / 64'd20;
    t   = one - ((x2 * t) >> 30) / 64'd6;
    s   = (x * t) >> 30;
    amp = (64'd1 << (sample_bits - 1)) - 64'd1;
    m   = (s * amp + (one >> 1)) >> 30;
    if (m > amp) begin
      m = amp;
    end
    return int'(m);
  endfunction

endpackage

// ===== hdl/mnso_in_if.sv =====
// Input event channel: valid/ready handshake carrying one MIDI event per beat.
interface mnso_in_if import mnso_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [NOTE_W-1:0] note_number;
  logic [VEL_W-1:0]  velocity;

  modport source (output valid, output op, output note_number, output velocity,
                  input ready);
  modport sink   (input valid, input op, input note_number, input velocity,
                  output ready);
endinterface

// ===== hdl/mnso_out_if.sv =====
// Sample output channel: valid/ready handshake carrying one audio sample per beat.
interface mnso_out_if import mnso_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== hdl/midi_note_sine_oscillator_core.sv =====
// Top level of the MIDI note sine oscillator: front end, command queue and back end.
//
//   Channel   Direction  Handshake      Beat contents
//   in_chan   input      valid/ready    op, note_number, velocity
//   out_chan  output     valid/ready    sample (signed, one per sample tick)
//   cfg_*     input      write enable   a4_phase_step
//
// One event beat is accepted per clock while the command queue is not full.
// A tick's sample passes the increment, ROM, product and divide registers to the output.
// Reset is synchronous and active low; it restores the A4 step, note 69, zero phase
// and silence. Output stalls freeze the back end while the two-entry queue keeps
// taking input beats until it fills.
module midi_note_sine_oscillator_core import mnso_pkg::*; #(
  parameter int PHASE_BITS     = PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [A4_W-1:0] cfg_wr_data,
  mnso_in_if.sink         in_chan,
  mnso_out_if.source      out_chan
);

  logic      q_push;
  logic      q_not_full;
  logic      q_not_empty;
  logic      q_pop;
  mnso_cmd_t q_in;
  mnso_cmd_t q_out;

  mnso_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .q_not_full (q_not_full),
    .q_push     (q_push),
    .q_cmd      (q_in)
  );

  mnso_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_in),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_cmd   (q_out)
  );

  mnso_back #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_ADDR_BITS (SINE_ADDR_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (q_not_empty),
    .cmd         (q_out),
    .cmd_pop     (q_pop),
    .out_chan    (out_chan)
  );

endmodule

// ===== hdl/mnso_sine_rom.sv =====
// Quarter-wave sine ROM with registered read data.
module mnso_sine_rom import mnso_pkg::*; #(
  parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [SINE_ADDR_BITS:0]  rd_addr,
  output logic [SAMPLE_BITS-2:0]   rd_data
);

  localparam int QSIZE = 1 << SINE_ADDR_BITS;
  localparam int AMP_W = SAMPLE_BITS - 1;

  typedef logic [AMP_W-1:0] rom_t [0:QSIZE];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i <= QSIZE; i++) begin
      r[i] = AMP_W'(sine_entry(i, SINE_ADDR_BITS, SAMPLE_BITS));
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [AMP_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= SINE_ROM[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/mnso_cmd_fifo.sv =====
// Short command queue between the event front end and the synthesis back end.
module mnso_cmd_fifo import mnso_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  mnso_cmd_t push_cmd,
  output logic      not_full,
  input  logic      pop,
  output logic      not_empty,
  output mnso_cmd_t pop_cmd
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  mnso_cmd_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign not_full  = (count_r != CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hdl/mnso_front.sv =====
// Event front end: accepts MIDI beats, drops unused codes and resolves pitch.
module mnso_front import mnso_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  mnso_in_if.sink   in_chan,
  input  logic      q_not_full,
  output logic      q_push,
  output mnso_cmd_t q_cmd
);

  logic [NOTE_W-1:0] cur_note_r;
  logic [NOTE_W-1:0] eff_note;
  logic              accept;
  note_split_t       split;

  assign in_chan.ready = q_not_full;
  assign accept        = in_chan.valid && q_not_full;
  assign eff_note      = (in_chan.op == OP_NOTE_ON) ? in_chan.note_number : cur_note_r;
  assign split         = note_split(eff_note);

  always_comb begin
    q_push         = 1'b0;
    q_cmd.kind     = CMD_TICK;
    q_cmd.semi     = split.semi;
    q_cmd.oct      = split.oct;
    q_cmd.velocity = in_chan.velocity;
    unique case (in_chan.op)
      OP_NOTE_ON: begin
        q_push     = accept;
        q_cmd.kind = CMD_NOTE_ON;
      end
      OP_NOTE_OFF: begin
        q_push     = accept;
        q_cmd.kind = CMD_NOTE_OFF;
      end
      OP_TICK: begin
        q_push     = accept;
        q_cmd.kind = CMD_TICK;
      end
      OP_UNUSED: begin
        q_push = 1'b0;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_note_r <= NOTE_RESET;
    end else if (accept && (in_chan.op == OP_NOTE_ON)) begin
      cur_note_r <= in_chan.note_number;
    end
  end

endmodule

// ===== hdl/mnso_back.sv =====
// Synthesis back end: increment pipeline, phase accumulator, sine lookup and scaling.
module mnso_back import mnso_pkg::*; #(
  parameter int PHASE_BITS     = PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [A4_W-1:0]  cfg_wr_data,
  input  logic             cmd_valid,
  input  mnso_cmd_t        cmd,
  output logic             cmd_pop,
  mnso_out_if.source       out_chan
);

  localparam int PROD_W  = A4_W + RATIO_W;
  localparam int SH_W    = PROD_W + (2 ** OCT_W) - 1;
  localparam int INCF_W  = SH_W - INC_SHIFT;
  localparam int AMP_W   = SAMPLE_BITS - 1;
  localparam int PW      = AMP_W + VEL_W;
  localparam int DIV_SH  = PW + VEL_W;
  localparam int RW      = PW + 1;
  localparam int QP_W    = PW + RW;
  localparam longint unsigned RECIP_L = ((64'd1 << DIV_SH) + VEL_FULL - 1) / VEL_FULL;
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
  localparam logic [SINE_ADDR_BITS:0] QUARTER = (SINE_ADDR_BITS + 1)'(2 ** SINE_ADDR_BITS);

  logic                   adv;
  logic [A4_W-1:0]        a4_r;

  logic                   v1_r;
  cmd_kind_t              kind1_r;
  logic [PROD_W-1:0]      prod1_r;
  logic [OCT_W-1:0]       oct1_r;
  logic [VEL_W-1:0]       vel1_r;

  logic                   v2_r;
  cmd_kind_t              kind2_r;
  logic [PHASE_BITS-1:0]  inc2_r;
  logic [VEL_W-1:0]       vel2_r;
  logic [SH_W-1:0]        shifted;
  logic [PHASE_BITS+INCF_W-1:0] inc_ext;

  logic [PHASE_BITS-1:0]  phase_r;
  logic [VEL_W-1:0]       loud_r;
  logic                   v3_r;
  logic                   neg3_r;
  logic [VEL_W-1:0]       loud3_r;
  logic [1:0]             quad;
  logic [SINE_ADDR_BITS:0] idx_ext;
  logic [SINE_ADDR_BITS:0] rom_addr;
  logic [AMP_W-1:0]       rom_data;
  logic                   tick2;

  logic                   v4_r;
  logic                   neg4_r;
  logic [PW-1:0]          m4_r;

  logic                   v5_r;
  logic                   neg5_r;
  logic [AMP_W-1:0]       q5_r;
  logic [QP_W-1:0]        qprod;

  logic                   vout_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [SAMPLE_BITS-1:0] mag_ext;

  assign adv     = !vout_r || out_chan.ready;
  assign cmd_pop = adv && cmd_valid;

  assign shifted = {{(SH_W - PROD_W){1'b0}}, prod1_r} << oct1_r;
  assign inc_ext = {{PHASE_BITS{1'b0}}, shifted[SH_W-1:INC_SHIFT]};

  assign quad     = phase_r[PHASE_BITS-1 -: 2];
  assign idx_ext  = {1'b0, phase_r[PHASE_BITS-3 -: SINE_ADDR_BITS]};
  assign rom_addr = quad[0] ? (QUARTER - idx_ext) : idx_ext;
  assign tick2    = v2_r && (kind2_r == CMD_TICK);

  assign qprod   = QP_W'(m4_r) * QP_W'(RECIP);
  assign mag_ext = SAMPLE_BITS'({1'b0, q5_r});

  mnso_sine_rom #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_rom (
    .clk     (clk),
    .rd_en   (adv),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a4_r <= A4_RESET;
    end else if (cfg_wr_en) begin
      a4_r <= cfg_wr_data;
    end
  end

  // Payload stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      kind1_r <= cmd.kind;
      prod1_r <= PROD_W'(a4_r) * PROD_W'(ratio_lut(cmd.semi));
      oct1_r  <= cmd.oct;
      vel1_r  <= cmd.velocity;
      kind2_r <= kind1_r;
      inc2_r  <= inc_ext[PHASE_BITS-1:0];
      vel2_r  <= vel1_r;
      neg3_r  <= quad[1];
      loud3_r <= loud_r;
      neg4_r  <= neg3_r;
      m4_r    <= PW'(rom_data) * PW'(loud3_r);
      neg5_r  <= neg4_r;
      q5_r    <= qprod[DIV_SH +: AMP_W];
      if (v5_r) begin
        sample_r <= neg5_r ? (~mag_ext + 1'b1) : mag_ext;
      end
    end
  end

  // Valid bits and oscillator state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      vout_r  <= 1'b0;
      phase_r <= '0;
      loud_r  <= '0;
    end else if (adv) begin
      v1_r   <= cmd_valid;
      v2_r   <= v1_r;
      v3_r   <= tick2;
      v4_r   <= v3_r;
      v5_r   <= v4_r;
      vout_r <= v5_r;
      if (v2_r) begin
        unique case (kind2_r)
          CMD_NOTE_ON: begin
            phase_r <= '0;
            loud_r  <= vel2_r;
          end
          CMD_NOTE_OFF: begin
            loud_r <= '0;
          end
          CMD_TICK: begin
            phase_r <= phase_r + inc2_r;
          end
          default: begin
            loud_r <= loud_r;
          end
        endcase
      end
    end
  end

  assign out_chan.valid  = vout_r;
  assign out_chan.sample = sample_r;

endmodule
